/* hw/rtl/backlight_sleep_controller_unit_assert.svh */
// Assertion macros for the backlight sleep controller.
`ifndef BACKLIGHT_SLEEP_CONTROLLER_UNIT_ASSERT_SVH
`define BACKLIGHT_SLEEP_CONTROLLER_UNIT_ASSERT_SVH

`ifndef SYNTH
`define BLSC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("blsc assertion failed");
`define BLSC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("blsc assertion failed");
`else
`define BLSC_ASSERT(label, clk, rst_n, prop)
`define BLSC_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

/* hw/rtl/blsc_pkg.sv */
// Types, constants and the brightness table of the backlight sleep controller.
package blsc_pkg;

  typedef enum logic [1:0] {
    FUNC_TICK     = 2'd0,
    FUNC_ACTIVITY = 2'd1,
    FUNC_HINT     = 2'd2,
    FUNC_POWER    = 2'd3
  } func_e;

  localparam logic [23:0] TimeoutReset  = 24'd30000;
  localparam logic [11:0] HintWindowMs  = 12'd2000;
  localparam logic [23:0] DimSpanMs     = 24'd2000;
  localparam logic [15:0] PressLimitMs  = 16'd1000;
  localparam logic [3:0]  FallbackLevel = 4'd7;
  localparam logic [3:0]  MaxLevel      = 4'd10;
  localparam logic [7:0]  DimFull       = 8'd255;
  localparam logic [12:0] Recip25       = 13'd5243;

  function automatic logic [7:0] level_raw(input logic [3:0] lvl);
    logic [7:0] raw;
    case (lvl)
      4'd0:    raw = 8'd1;
      4'd1:    raw = 8'd8;
      4'd2:    raw = 8'd16;
      4'd3:    raw = 8'd32;
      4'd4:    raw = 8'd48;
      4'd5:    raw = 8'd72;
      4'd6:    raw = 8'd96;
      4'd7:    raw = 8'd128;
      4'd8:    raw = 8'd160;
      4'd9:    raw = 8'd192;
      default: raw = 8'd255;
    endcase
    return raw;
  endfunction

endpackage

/* hw/rtl/backlight_sleep_controller_unit.sv */
// Backlight sleep controller: screen on/off/hint state, idle timing and dim ramp.
//
// Input channel: in_valid_i with func_i, tick_ms_i, key_released_i, hold_ms_i
// and system_level_i; a beat is taken when in_valid_i is high and in_stall_o low.
// Output channel: out_valid_o with is_off_o, hint_shown_o, write_valid_o,
// kick_first_o, raw_brightness_o and dim_alpha_o; the receiver holds a beat by
// raising out_stall_i, and the beat stays unchanged until it is taken.
// Each input beat gives exactly one output beat, in order.
// A beat passes the input register first, then the result register.
// Throughput is one beat per cycle while the receiver does not stall; the state
// update and the dim ramp are one pass of logic between the two registers.
// in_stall_o rises only when both registers hold beats and out_stall_i is high.
// The timeout register is written through cfg_valid_i / cfg_ready_o with
// timeout_ms_i; cfg_ready_o is always high. Write it only while idle.
// Reset: screen on, hint off, counters cleared, saved level 7, timeout 30000 ms,
// both registers empty.
module backlight_sleep_controller_unit
  import blsc_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] timeout_ms_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  func_i,
  input  logic [15:0] tick_ms_i,
  input  logic        key_released_i,
  input  logic [15:0] hold_ms_i,
  input  logic [3:0]  system_level_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic        is_off_o,
  output logic        hint_shown_o,
  output logic        write_valid_o,
  output logic        kick_first_o,
  output logic [7:0]  raw_brightness_o,
  output logic [7:0]  dim_alpha_o
);

  `include "backlight_sleep_controller_unit_assert.svh"

  function automatic logic [3:0] system_level_i_q_fix(input logic [3:0] lvl);
    return (lvl <= MaxLevel) ? lvl : FallbackLevel;
  endfunction

  logic [23:0] timeout_q;
  logic        off_q, off_d;
  logic        hint_q, hint_d;
  logic [23:0] idle_q, idle_d;
  logic [11:0] hcnt_q, hcnt_d;
  logic [3:0]  saved_q, saved_d;

  logic        iv_q;
  func_e       func_q;
  logic [15:0] elapsed_q;
  logic        released_q;
  logic [15:0] hold_q;
  logic [3:0]  level_q;

  logic        ov_q;
  logic        is_off_q, hint_shown_q, wr_valid_q, kick_q;
  logic [7:0]  raw_q, dim_q;

  logic        wr_valid_d, kick_d;
  logic [7:0]  raw_d, dim_d;
  logic        out_load, move, in_load;

  logic [24:0] idle_sum;
  logic [23:0] idle_sat;
  logic [16:0] hint_sum;
  logic [11:0] hint_sat;
  logic [3:0]  level_fix;
  logic        short_press;

  logic [23:0] ramp_base, dim_past;
  logic [16:0] dim_x51;
  logic [12:0] dim_y;
  logic [25:0] dim_prod;

  assign cfg_ready_o = 1'b1;

  assign out_load   = !ov_q || !out_stall_i;
  assign move       = iv_q && out_load;
  assign in_load    = !iv_q || move;
  assign in_stall_o = !in_load;

  assign idle_sum    = {1'b0, idle_q} + {9'd0, elapsed_q};
  assign idle_sat    = idle_sum[24] ? '1 : idle_sum[23:0];
  assign hint_sum    = {5'd0, hcnt_q} + {1'b0, elapsed_q};
  assign hint_sat    = (|hint_sum[16:12]) ? '1 : hint_sum[11:0];
  assign level_fix   = (system_level_i_q_fix(level_q));
  assign short_press = released_q && (hold_q < PressLimitMs);

  always_comb begin
    off_d      = off_q;
    hint_d     = hint_q;
    idle_d     = idle_q;
    hcnt_d     = hcnt_q;
    saved_d    = saved_q;
    wr_valid_d = 1'b0;
    kick_d     = 1'b0;
    raw_d      = 8'd0;
    case (func_q)
      FUNC_TICK: begin
        if (!off_q) begin
          idle_d = idle_sat;
          if ((timeout_q != 24'd0) && (idle_sat >= timeout_q)) begin
            saved_d    = level_fix;
            wr_valid_d = 1'b1;
            off_d      = 1'b1;
            hint_d     = 1'b0;
            hcnt_d     = 12'd0;
          end
        end else if (hint_q) begin
          hcnt_d = hint_sat;
          if (hint_sat >= HintWindowMs) begin
            hint_d     = 1'b0;
            hcnt_d     = 12'd0;
            wr_valid_d = 1'b1;
          end
        end
      end
      FUNC_ACTIVITY: begin
        idle_d = 24'd0;
        if (off_q) begin
          wr_valid_d = 1'b1;
          kick_d     = 1'b1;
          raw_d      = level_raw(saved_q);
          off_d      = 1'b0;
          hint_d     = 1'b0;
          hcnt_d     = 12'd0;
        end
      end
      FUNC_HINT: begin
        if (off_q) begin
          wr_valid_d = 1'b1;
          kick_d     = 1'b1;
          raw_d      = level_raw(saved_q);
          hint_d     = 1'b1;
          hcnt_d     = 12'd0;
        end
      end
      default: begin
        if (short_press) begin
          if (off_q) begin
            wr_valid_d = 1'b1;
            kick_d     = 1'b1;
            raw_d      = level_raw(saved_q);
            off_d      = 1'b0;
            hint_d     = 1'b0;
            hcnt_d     = 12'd0;
            idle_d     = 24'd0;
          end else begin
            saved_d    = level_fix;
            wr_valid_d = 1'b1;
            off_d      = 1'b1;
            hint_d     = 1'b0;
            hcnt_d     = 12'd0;
          end
        end
      end
    endcase
  end

  // dim ramp: 255 * past / 2000 = ((51 * past) >> 4) / 25
  assign ramp_base = timeout_q - DimSpanMs;
  assign dim_past  = idle_d - ramp_base;
  assign dim_x51   = {6'd0, dim_past[10:0]} * 17'd51;
  assign dim_y     = dim_x51[16:4];
  assign dim_prod  = {13'd0, dim_y} * {13'd0, Recip25};

  always_comb begin
    if (off_d || (timeout_q <= DimSpanMs) || (idle_d < ramp_base)) begin
      dim_d = 8'd0;
    end else if (dim_past >= DimSpanMs) begin
      dim_d = DimFull;
    end else begin
      dim_d = dim_prod[24:17];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (cfg_valid_i && cfg_ready_o) begin
      timeout_q <= timeout_ms_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      off_q   <= 1'b0;
      hint_q  <= 1'b0;
      idle_q  <= 24'd0;
      hcnt_q  <= 12'd0;
      saved_q <= FallbackLevel;
    end else if (move) begin
      off_q   <= off_d;
      hint_q  <= hint_d;
      idle_q  <= idle_d;
      hcnt_q  <= hcnt_d;
      saved_q <= saved_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iv_q <= 1'b0;
    end else if (in_load) begin
      iv_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_load && in_valid_i) begin
      func_q     <= func_e'(func_i);
      elapsed_q  <= tick_ms_i;
      released_q <= key_released_i;
      hold_q     <= hold_ms_i;
      level_q    <= system_level_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (out_load) begin
      ov_q <= iv_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (move) begin
      is_off_q     <= off_d;
      hint_shown_q <= hint_d;
      wr_valid_q   <= wr_valid_d;
      kick_q       <= kick_d;
      raw_q        <= raw_d;
      dim_q        <= dim_d;
    end
  end

  assign out_valid_o      = ov_q;
  assign is_off_o         = is_off_q;
  assign hint_shown_o     = hint_shown_q;
  assign write_valid_o    = wr_valid_q;
  assign kick_first_o     = kick_q;
  assign raw_brightness_o = raw_q;
  assign dim_alpha_o      = dim_q;

  `BLSC_ASSERT(a_no_write_clean, clk_i, rst_ni,
    out_valid_o && !write_valid_o |-> !kick_first_o && (raw_brightness_o == 8'd0))
  `BLSC_ASSERT(a_hint_only_off, clk_i, rst_ni,
    out_valid_o && hint_shown_o |-> is_off_o)
  `BLSC_ASSERT(a_wake_lit, clk_i, rst_ni,
    out_valid_o && kick_first_o |-> write_valid_o && (raw_brightness_o != 8'd0))
  `BLSC_ASSERT(a_dim_only_on, clk_i, rst_ni,
    out_valid_o && (dim_alpha_o != 8'd0) |-> !is_off_o)
  `BLSC_ASSERT_ALWAYS(a_saved_range, clk_i, saved_q <= MaxLevel)

endmodule

/* tb/tb_top.sv */
// Testbench for the backlight sleep controller: predictor, handshake drivers and random events.
module tb_top;
  import blsc_pkg::*;

  localparam int unsigned TIMEOUT_AT_RESET = 30000;
  localparam int unsigned HINT_WINDOW_MS   = 2000;
  localparam int unsigned DIM_SPAN_MS      = 2000;
  localparam int unsigned PRESS_LIMIT_MS   = 1000;
  localparam int unsigned IDLE_MAX         = 24'hFFFFFF;
  localparam int unsigned HINT_MAX         = 12'hFFF;
  localparam logic [3:0]  FALLBACK_LEVEL   = 4'd7;
  localparam logic [3:0]  TOP_LEVEL        = 4'd10;
  localparam int          MAX_GAP          = 6;
  localparam int          CYCLE_LIMIT      = 200000;
  localparam int          PHASE_ITEMS      = 33;
  localparam int          SATURATE_TICKS   = 260;

  typedef struct packed {
    func_e       func;
    logic [15:0] tick_ms;
    logic        key_released;
    logic [15:0] hold_ms;
    logic [3:0]  system_level;
  } sleep_event_t;

  typedef struct packed {
    logic       is_off;
    logic       hint_shown;
    logic       write_valid;
    logic       kick_first;
    logic [7:0] raw_brightness;
    logic [7:0] dim_alpha;
  } sleep_result_t;

  class sleep_scoreboard;
    logic [23:0]   timeout;
    logic          off;
    logic          hint;
    logic [23:0]   idle_ms;
    logic [11:0]   hint_ms;
    logic [3:0]    saved_level;
    sleep_result_t expected_q[$];
    int            errors;

    function new();
      timeout     = 24'(TIMEOUT_AT_RESET);
      off         = 1'b0;
      hint        = 1'b0;
      idle_ms     = '0;
      hint_ms     = '0;
      saved_level = FALLBACK_LEVEL;
      errors      = 0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function logic [7:0] raw_for_level(input logic [3:0] lvl);
      case (lvl)
        4'd0:    return 8'd1;
        4'd1:    return 8'd8;
        4'd2:    return 8'd16;
        4'd3:    return 8'd32;
        4'd4:    return 8'd48;
        4'd5:    return 8'd72;
        4'd6:    return 8'd96;
        4'd7:    return 8'd128;
        4'd8:    return 8'd160;
        4'd9:    return 8'd192;
        default: return 8'd255;
      endcase
    endfunction

    function void show_saved(inout sleep_result_t r);
      r.write_valid    = 1'b1;
      r.kick_first     = 1'b1;
      r.raw_brightness = raw_for_level(saved_level > TOP_LEVEL ? TOP_LEVEL : saved_level);
    endfunction

    function void blank(input logic [3:0] sys_level, inout sleep_result_t r);
      if (off) return;
      saved_level      = (sys_level <= TOP_LEVEL) ? sys_level : FALLBACK_LEVEL;
      r.write_valid    = 1'b1;
      r.kick_first     = 1'b0;
      r.raw_brightness = 8'd0;
      off              = 1'b1;
      hint             = 1'b0;
      hint_ms          = '0;
    endfunction

    function void wake(inout sleep_result_t r);
      if (!off) return;
      show_saved(r);
      off     = 1'b0;
      hint    = 1'b0;
      hint_ms = '0;
      idle_ms = '0;
    endfunction

    function logic [7:0] dim_level();
      int unsigned start;
      int unsigned past;
      if (off || timeout <= DIM_SPAN_MS) return 8'd0;
      start = timeout - DIM_SPAN_MS;
      if (idle_ms < start) return 8'd0;
      past = idle_ms - start;
      if (past >= DIM_SPAN_MS) return 8'd255;
      return 8'((255 * past) / DIM_SPAN_MS);
    endfunction

    function void note_event(input sleep_event_t ev);
      sleep_result_t r;
      int unsigned   sum;
      r = '0;
      case (ev.func)
        FUNC_TICK: begin
          if (!off) begin
            sum     = idle_ms + ev.tick_ms;
            idle_ms = (sum > IDLE_MAX) ? 24'(IDLE_MAX) : 24'(sum);
            if (timeout != 0 && idle_ms >= timeout) blank(ev.system_level, r);
          end else if (hint) begin
            sum     = hint_ms + ev.tick_ms;
            hint_ms = (sum > HINT_MAX) ? 12'(HINT_MAX) : 12'(sum);
            if (hint_ms >= HINT_WINDOW_MS) begin
              hint          = 1'b0;
              hint_ms       = '0;
              r.write_valid = 1'b1;
            end
          end
        end
        FUNC_ACTIVITY: begin
          idle_ms = '0;
          wake(r);
        end
        FUNC_HINT: begin
          if (off) begin
            show_saved(r);
            hint    = 1'b1;
            hint_ms = '0;
          end
        end
        default: begin
          if (ev.key_released && ev.hold_ms < PRESS_LIMIT_MS) begin
            if (off) wake(r);
            else blank(ev.system_level, r);
          end
        end
      endcase
      r.is_off     = off;
      r.hint_shown = hint;
      r.dim_alpha  = dim_level();
      expected_q.push_back(r);
    endfunction

    function void check_field(input string name, input int unsigned want,
                              input int unsigned got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(input sleep_result_t got);
      sleep_result_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: result beat with nothing expected, actual %h", $time, got);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      check_field("is_off", 32'(want.is_off), 32'(got.is_off));
      check_field("hint_shown", 32'(want.hint_shown), 32'(got.hint_shown));
      check_field("write_valid", 32'(want.write_valid), 32'(got.write_valid));
      check_field("kick_first", 32'(want.kick_first), 32'(got.kick_first));
      check_field("raw_brightness", 32'(want.raw_brightness), 32'(got.raw_brightness));
      check_field("dim_alpha", 32'(want.dim_alpha), 32'(got.dim_alpha));
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni         = 1'b0;
  logic        cfg_valid      = 1'b0;
  logic        cfg_ready;
  logic [23:0] timeout_cfg    = '0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic [1:0]  func_d         = '0;
  logic [15:0] elapsed_d      = '0;
  logic        released_d     = 1'b0;
  logic [15:0] hold_d         = '0;
  logic [3:0]  level_d        = '0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic        is_off;
  logic        hint_shown;
  logic        write_valid;
  logic        kick_first;
  logic [7:0]  raw_brightness;
  logic [7:0]  dim_alpha;

  sleep_scoreboard sb;
  bit              calm = 1'b0;
  int              stall_left = 0;
  int              cycle_count = 0;

  backlight_sleep_controller_unit uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid),
    .cfg_ready_o     (cfg_ready),
    .timeout_ms_i    (timeout_cfg),
    .in_valid_i      (in_valid),
    .in_stall_o      (in_stall),
    .func_i          (func_d),
    .tick_ms_i       (elapsed_d),
    .key_released_i  (released_d),
    .hold_ms_i       (hold_d),
    .system_level_i  (level_d),
    .out_valid_o     (out_valid),
    .out_stall_i     (out_stall),
    .is_off_o        (is_off),
    .hint_shown_o    (hint_shown),
    .write_valid_o   (write_valid),
    .kick_first_o    (kick_first),
    .raw_brightness_o(raw_brightness),
    .dim_alpha_o     (dim_alpha)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall)
        sb.note_event('{func: func_e'(func_d), tick_ms: elapsed_d, key_released: released_d,
                        hold_ms: hold_d, system_level: level_d});
      if (out_valid && !out_stall)
        sb.check_result('{is_off: is_off, hint_shown: hint_shown, write_valid: write_valid,
                          kick_first: kick_first, raw_brightness: raw_brightness,
                          dim_alpha: dim_alpha});
    end
  end

  // hold each result beat for a random number of cycles
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid && !out_stall) stall_left = calm ? 0 : $urandom_range(0, MAX_GAP);
      else if (stall_left > 0) stall_left--;
      out_stall <= (stall_left > 0);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  function automatic sleep_event_t make_event(input func_e f, input int unsigned elapsed,
                                              input bit released, input int unsigned hold,
                                              input int unsigned level);
    sleep_event_t ev;
    ev.func         = f;
    ev.tick_ms      = 16'(elapsed);
    ev.key_released = released;
    ev.hold_ms      = 16'(hold);
    ev.system_level = 4'(level);
    return ev;
  endfunction

  function automatic sleep_event_t random_event();
    sleep_event_t ev;
    int           pick;
    pick    = $urandom_range(0, 19);
    ev.func = (pick < 10) ? FUNC_TICK : (pick < 13) ? FUNC_ACTIVITY :
              (pick < 16) ? FUNC_HINT : FUNC_POWER;
    case ($urandom_range(0, 7))
      0:       ev.tick_ms = 16'd0;
      1:       ev.tick_ms = 16'hFFFF;
      2, 3:    ev.tick_ms = 16'($urandom_range(0, 65535));
      default: ev.tick_ms = 16'($urandom_range(0, 2500));
    endcase
    ev.key_released = ($urandom_range(0, 5) != 0);
    case ($urandom_range(0, 5))
      0:       ev.hold_ms = 16'(PRESS_LIMIT_MS - 1);
      1:       ev.hold_ms = 16'(PRESS_LIMIT_MS);
      2:       ev.hold_ms = 16'($urandom_range(0, 65535));
      default: ev.hold_ms = 16'($urandom_range(0, PRESS_LIMIT_MS - 2));
    endcase
    ev.system_level = 4'($urandom_range(0, 15));
    return ev;
  endfunction

  task automatic drive_event(input sleep_event_t ev);
    int gap;
    gap = calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    func_d     <= ev.func;
    elapsed_d  <= ev.tick_ms;
    released_d <= ev.key_released;
    hold_d     <= ev.hold_ms;
    level_d    <= ev.system_level;
    do @(posedge clk_i); while (in_stall);
  endtask

  // drop valid and wait for every outstanding result
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_timeout(input logic [23:0] value);
    settle();
    cfg_valid   <= 1'b1;
    timeout_cfg <= value;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.timeout = value;
  endtask

  logic [23:0] timeouts[11];

  initial begin
    sb = new();
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    drive_event(make_event(FUNC_TICK, 0, 0, 0, 0));
    drive_event(make_event(FUNC_ACTIVITY, 65535, 1, 65535, 15));
    drive_event(make_event(FUNC_HINT, 0, 0, 0, 3));
    drive_event(make_event(FUNC_POWER, 0, 0, 0, 2));
    drive_event(make_event(FUNC_POWER, 0, 1, PRESS_LIMIT_MS, 2));
    drive_event(make_event(FUNC_POWER, 0, 1, 65535, 2));
    drive_event(make_event(FUNC_POWER, 0, 1, PRESS_LIMIT_MS - 1, 15));
    drive_event(make_event(FUNC_TICK, 65535, 0, 0, 4));
    drive_event(make_event(FUNC_HINT, 0, 0, 0, 4));
    drive_event(make_event(FUNC_HINT, 0, 0, 0, 4));
    drive_event(make_event(FUNC_TICK, HINT_WINDOW_MS - 1, 0, 0, 4));
    drive_event(make_event(FUNC_TICK, 1, 0, 0, 4));
    drive_event(make_event(FUNC_HINT, 0, 0, 0, 4));
    drive_event(make_event(FUNC_TICK, 65535, 0, 0, 4));
    drive_event(make_event(FUNC_POWER, 0, 1, 0, 4));
    drive_event(make_event(FUNC_TICK, 27999, 0, 0, 10));
    drive_event(make_event(FUNC_TICK, 1, 0, 0, 10));
    drive_event(make_event(FUNC_TICK, 1000, 0, 0, 10));
    drive_event(make_event(FUNC_TICK, 999, 0, 0, 10));
    drive_event(make_event(FUNC_TICK, 1, 0, 0, 10));
    drive_event(make_event(FUNC_ACTIVITY, 0, 0, 0, 0));
    drive_event(make_event(FUNC_POWER, 0, 1, 0, 0));
    drive_event(make_event(FUNC_ACTIVITY, 0, 0, 0, 0));
    drive_event(make_event(FUNC_ACTIVITY, 0, 0, 0, 0));

    timeouts = '{24'd0, 24'hFFFFFF, 24'd1, 24'd2000, 24'd2001,
                 24'($urandom_range(2001, 12000)), 24'($urandom_range(2001, 12000)),
                 24'($urandom_range(2001, 12000)), 24'($urandom_range(2001, 40000)),
                 24'($urandom_range(0, 24'hFFFFFF)), 24'(TIMEOUT_AT_RESET)};

    foreach (timeouts[p]) begin
      write_timeout(timeouts[p]);
      calm = ($urandom_range(0, 3) == 0);
      if (p == 0) begin
        for (int k = 0; k < SATURATE_TICKS; k++)
          drive_event(make_event(FUNC_TICK, 65535, 0, 0, $urandom_range(0, 15)));
      end
      if (p == 1) drive_event(make_event(FUNC_TICK, 0, 0, 0, 9));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if ($urandom_range(0, 29) == 0) calm = !calm;
        drive_event(random_event());
      end
    end

    settle();
    repeat (10) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+hw/rtl
hw/rtl/blsc_pkg.sv
hw/rtl/backlight_sleep_controller_unit.sv
tb/tb_top.sv
